// ===== hdl/pfre_pkg.sv =====
package pfre_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGES;
  localparam int AW            = $clog2(STORE_BYTES);

  localparam logic [3:0] CMD_PIXEL  = 4'd0;
  localparam logic [3:0] CMD_LINE   = 4'd1;
  localparam logic [3:0] CMD_RECT   = 4'd2;
  localparam logic [3:0] CMD_FRECT  = 4'd3;
  localparam logic [3:0] CMD_CIRCLE = 4'd4;
  localparam logic [3:0] CMD_FCIRC  = 4'd5;
  localparam logic [3:0] CMD_GLYPH  = 4'd6;
  localparam logic [3:0] CMD_CLEAR  = 4'd7;
  localparam logic [3:0] CMD_FILL   = 4'd8;
  localparam logic [3:0] CMD_READ   = 4'd9;

  localparam logic [7:0] CHAR_LO       = 8'd32;
  localparam logic [7:0] CHAR_HI       = 8'd126;
  localparam logic [7:0] CHAR_FALLBACK = 8'd63;
  localparam int GLYPH_COLS = 5;
  localparam int CELL_COLS  = 6;
  localparam int GLYPH_ROWS = 7;

  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [7:0] CLEAR_BYTE = 8'h00;

  typedef logic signed [15:0] crd_t;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [11:0] x_a;
    logic signed [11:0] y_a;
    logic signed [11:0] x_b;
    logic signed [11:0] y_b;
    logic signed [11:0] width_span;
    logic signed [11:0] height_span;
    logic [10:0]        radius;
    logic [7:0]         char_code;
    logic               ink;
    logic [9:0]         read_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
  } res_t;

  localparam logic [7:0] FONT [475] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h01,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h32, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h00,8'h7F,8'h10,8'h28,8'h44, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h08,8'h2A,8'h1C,8'h08
  };

endpackage

// ===== hdl/pfre_if.sv =====
interface pfre_cmd_if;
  logic            valid;
  logic            ready;
  pfre_pkg::cmd_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pfre_res_if;
  logic            valid;
  logic            ready;
  pfre_pkg::res_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/page_framebuffer_raster_engine_top.sv =====
// channel  dir  handshake     payload
// cmd      in   valid/ready   command, coordinates, spans, radius, char_code, ink, read_index
// res      out  valid/ready   read_data, read_valid
//
// one command at a time; every plotted pixel is a read then a write of the frame store
// (one read port, one write port), and a clipped pixel is skipped without a write
// clear and fill sweep the store at one byte a cycle (store size, 1024 bytes)
// after reset a clearing pass over all 1024 bytes runs before the first request is taken
// a finished result waits in its register; the next request is taken meanwhile, and
// the block holds at its end until the previous result has gone
module page_framebuffer_raster_engine_top (
  input logic clk,
  input logic rst,
  pfre_cmd_if.sink cmd,
  pfre_res_if.source res
);

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_PA, S_PB, S_RUN, S_LINE, S_LSTEP, S_ROUT, S_FROW,
    S_CFIRST, S_CTOP, S_CPT, S_CUPD, S_GPT, S_RDA, S_RDB, S_DONE
  } state_t;

  localparam pfre_pkg::crd_t SW_C = pfre_pkg::crd_t'(pfre_pkg::SCREEN_WIDTH);
  localparam pfre_pkg::crd_t SH_C = pfre_pkg::crd_t'(pfre_pkg::SCREEN_HEIGHT);
  localparam pfre_pkg::crd_t ONE_C = pfre_pkg::crd_t'(1);
  localparam logic [pfre_pkg::AW-1:0] LAST_ADDR = pfre_pkg::AW'(pfre_pkg::STORE_BYTES - 1);

  state_t state, ret, run_ret;
  logic [7:0] mem [pfre_pkg::STORE_BYTES];
  logic [7:0] mem_rdata;
  logic mem_we;
  logic [pfre_pkg::AW-1:0] mem_waddr, mem_raddr, pix_addr, sweep_cnt;
  logic [7:0] mem_wdata, pix_mask;
  logic sweep_val, boot;
  logic [9:0] cmd_read_index_q;

  pfre_pkg::crd_t ax, ay, bx, by, wd, ht, dx, dy, err;
  logic sxn, syn;
  pfre_pkg::crd_t row, rowend;
  pfre_pkg::crd_t cxr, cyv, cerr;
  logic [3:0] k;
  logic fill_c;
  logic [8:0] gbase;
  logic [2:0] gcol, grow;
  pfre_pkg::crd_t run_pos, run_end, run_fix;
  logic run_vert;
  pfre_pkg::crd_t px, py;
  logic pon, on;
  logic is_read, rd_ok;
  logic [7:0] rd_byte;
  logic out_valid;
  pfre_pkg::res_t out_data;

  pfre_pkg::crd_t ppx, ppy;
  logic pval;
  pfre_pkg::crd_t rs, rl, rf;
  logic rv;
  logic pix_in;
  pfre_pkg::crd_t e2, err_next, dstep_x, dstep_y;
  logic mv_x, mv_y;
  pfre_pkg::crd_t cu_y, cu_e1, cu_x, cu_e;
  logic [8:0] gidx;
  logic gbit;
  logic [7:0] code_m;

  function automatic pfre_pkg::crd_t cmax0(pfre_pkg::crd_t v);
    return (v < 0) ? pfre_pkg::crd_t'(0) : v;
  endfunction

  function automatic pfre_pkg::crd_t cmin(pfre_pkg::crd_t a, pfre_pkg::crd_t b);
    return (a < b) ? a : b;
  endfunction

  assign pix_in = (px >= 0) && (px < SW_C) && (py >= 0) && (py < SH_C);
  assign pix_addr = pfre_pkg::AW'(32'(py[15:3]) * 32'(pfre_pkg::SCREEN_WIDTH) + 32'(px[14:0]));
  assign pix_mask = 8'd1 << py[2:0];

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = pon ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
    mem_raddr = pix_addr;
    if (state == S_SWEEP) begin
      mem_we = 1'b1;
      mem_waddr = sweep_cnt;
      mem_wdata = sweep_val ? pfre_pkg::FILL_BYTE : pfre_pkg::CLEAR_BYTE;
    end else if (state == S_PB) begin
      mem_we = 1'b1;
    end
    if (state == S_RDA) mem_raddr = pfre_pkg::AW'(cmd_read_index_q);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // line step
  always_comb begin
    e2 = err + err;
    mv_x = e2 > -dy;
    mv_y = e2 < dx;
    err_next = err - (mv_x ? dy : pfre_pkg::crd_t'(0)) + (mv_y ? dx : pfre_pkg::crd_t'(0));
    dstep_x = sxn ? pfre_pkg::crd_t'(-1) : pfre_pkg::crd_t'(1);
    dstep_y = syn ? pfre_pkg::crd_t'(-1) : pfre_pkg::crd_t'(1);
  end

  // midpoint circle update
  always_comb begin
    cu_y = cyv + ONE_C;
    cu_e1 = (cerr <= 0) ? (cerr + cu_y + cu_y + ONE_C) : cerr;
    cu_x = (cu_e1 > 0) ? (cxr - ONE_C) : cxr;
    cu_e = (cu_e1 > 0) ? (cu_e1 - (cu_x + cu_x + ONE_C)) : cu_e1;
  end

  always_comb begin
    gidx = (gcol < 3'(pfre_pkg::GLYPH_COLS)) ? (gbase + 9'(gcol)) : gbase;
    gbit = (gcol < 3'(pfre_pkg::GLYPH_COLS)) ? pfre_pkg::FONT[gidx][grow] : 1'b0;
    code_m = (cmd.payload.char_code < pfre_pkg::CHAR_LO ||
              cmd.payload.char_code > pfre_pkg::CHAR_HI) ?
             pfre_pkg::CHAR_FALLBACK : cmd.payload.char_code;
  end

  // pixel request
  always_comb begin
    ppx = px;
    ppy = py;
    pval = on;
    case (state)
      S_IDLE: begin
        ppx = pfre_pkg::crd_t'(cmd.payload.x_a);
        ppy = pfre_pkg::crd_t'(cmd.payload.y_a);
        pval = cmd.payload.ink;
      end
      S_LINE: begin
        ppx = ax;
        ppy = ay;
      end
      S_RUN: begin
        ppx = run_vert ? run_fix : run_pos;
        ppy = run_vert ? run_pos : run_fix;
      end
      S_CPT: begin
        case (k[2:0])
          3'd0: begin ppx = ax + cxr; ppy = ay + cyv; end
          3'd1: begin ppx = ax + cyv; ppy = ay + cxr; end
          3'd2: begin ppx = ax - cyv; ppy = ay + cxr; end
          3'd3: begin ppx = ax - cxr; ppy = ay + cyv; end
          3'd4: begin ppx = ax - cxr; ppy = ay - cyv; end
          3'd5: begin ppx = ax - cyv; ppy = ay - cxr; end
          3'd6: begin ppx = ax + cyv; ppy = ay - cxr; end
          default: begin ppx = ax + cxr; ppy = ay - cyv; end
        endcase
      end
      S_GPT: begin
        ppx = ax + pfre_pkg::crd_t'(gcol);
        ppy = ay + pfre_pkg::crd_t'(grow);
        pval = gbit ? on : !on;
      end
      default: ;
    endcase
  end

  // run request
  always_comb begin
    rs = ax;
    rl = wd;
    rf = ay;
    rv = 1'b0;
    case (state)
      S_ROUT: begin
        case (k[1:0])
          2'd0: begin rs = ax; rf = ay; rl = wd; rv = 1'b0; end
          2'd1: begin rs = ax; rf = ay + ht - ONE_C; rl = wd; rv = 1'b0; end
          2'd2: begin rs = ay; rf = ax; rl = ht; rv = 1'b1; end
          default: begin rs = ay; rf = ax + wd - ONE_C; rl = ht; rv = 1'b1; end
        endcase
      end
      S_FROW: begin
        rs = ax; rf = row; rl = wd; rv = 1'b0;
      end
      S_CFIRST: begin
        rs = ay - cxr; rf = ax; rl = cxr + cxr + ONE_C; rv = 1'b1;
      end
      S_CPT: begin
        rv = 1'b1;
        case (k[1:0])
          2'd0: begin rf = ax + cxr; rs = ay - cyv; rl = cyv + cyv + ONE_C; end
          2'd1: begin rf = ax - cxr; rs = ay - cyv; rl = cyv + cyv + ONE_C; end
          2'd2: begin rf = ax + cyv; rs = ay - cxr; rl = cxr + cxr + ONE_C; end
          default: begin rf = ax - cyv; rs = ay - cxr; rl = cxr + cxr + ONE_C; end
        endcase
      end
      default: ;
    endcase
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      ret <= S_IDLE;
      run_ret <= S_IDLE;
      sweep_cnt <= '0;
      sweep_val <= 1'b0;
      boot <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_SWEEP: begin
          if (sweep_cnt == LAST_ADDR) begin
            sweep_cnt <= '0;
            boot <= 1'b0;
            state <= boot ? S_IDLE : S_DONE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            ax <= pfre_pkg::crd_t'(cmd.payload.x_a);
            ay <= pfre_pkg::crd_t'(cmd.payload.y_a);
            bx <= pfre_pkg::crd_t'(cmd.payload.x_b);
            by <= pfre_pkg::crd_t'(cmd.payload.y_b);
            wd <= pfre_pkg::crd_t'(cmd.payload.width_span);
            ht <= pfre_pkg::crd_t'(cmd.payload.height_span);
            on <= cmd.payload.ink;
            cmd_read_index_q <= cmd.payload.read_index;
            is_read <= 1'b0;
            k <= '0;
            cxr <= pfre_pkg::crd_t'(cmd.payload.radius);
            cyv <= '0;
            cerr <= '0;
            gcol <= '0;
            grow <= '0;
            gbase <= 9'(code_m - pfre_pkg::CHAR_LO) * 9'd5;
            row <= cmax0(pfre_pkg::crd_t'(cmd.payload.y_a));
            rowend <= cmin(pfre_pkg::crd_t'(cmd.payload.y_a) +
                           pfre_pkg::crd_t'(cmd.payload.height_span), SH_C);
            unique case (cmd.payload.command)
              pfre_pkg::CMD_PIXEL: begin
                px <= ppx;
                py <= ppy;
                pon <= pval;
                ret <= S_DONE;
                state <= S_PA;
              end
              pfre_pkg::CMD_LINE: begin
                dx <= (cmd.payload.x_b > cmd.payload.x_a) ?
                      pfre_pkg::crd_t'(cmd.payload.x_b) - pfre_pkg::crd_t'(cmd.payload.x_a) :
                      pfre_pkg::crd_t'(cmd.payload.x_a) - pfre_pkg::crd_t'(cmd.payload.x_b);
                dy <= (cmd.payload.y_b > cmd.payload.y_a) ?
                      pfre_pkg::crd_t'(cmd.payload.y_b) - pfre_pkg::crd_t'(cmd.payload.y_a) :
                      pfre_pkg::crd_t'(cmd.payload.y_a) - pfre_pkg::crd_t'(cmd.payload.y_b);
                err <= ((cmd.payload.x_b > cmd.payload.x_a) ?
                        pfre_pkg::crd_t'(cmd.payload.x_b) - pfre_pkg::crd_t'(cmd.payload.x_a) :
                        pfre_pkg::crd_t'(cmd.payload.x_a) - pfre_pkg::crd_t'(cmd.payload.x_b)) -
                       ((cmd.payload.y_b > cmd.payload.y_a) ?
                        pfre_pkg::crd_t'(cmd.payload.y_b) - pfre_pkg::crd_t'(cmd.payload.y_a) :
                        pfre_pkg::crd_t'(cmd.payload.y_a) - pfre_pkg::crd_t'(cmd.payload.y_b));
                sxn <= !(cmd.payload.x_a < cmd.payload.x_b);
                syn <= !(cmd.payload.y_a < cmd.payload.y_b);
                state <= S_LINE;
              end
              pfre_pkg::CMD_RECT: begin
                if (cmd.payload.width_span > 0 && cmd.payload.height_span > 0)
                  state <= S_ROUT;
                else
                  state <= S_DONE;
              end
              pfre_pkg::CMD_FRECT: begin
                if (cmd.payload.width_span > 0 && cmd.payload.height_span > 0)
                  state <= S_FROW;
                else
                  state <= S_DONE;
              end
              pfre_pkg::CMD_CIRCLE: begin
                fill_c <= 1'b0;
                state <= S_CTOP;
              end
              pfre_pkg::CMD_FCIRC: begin
                fill_c <= 1'b1;
                state <= S_CFIRST;
              end
              pfre_pkg::CMD_GLYPH: state <= S_GPT;
              pfre_pkg::CMD_CLEAR: begin
                sweep_val <= 1'b0;
                sweep_cnt <= '0;
                state <= S_SWEEP;
              end
              pfre_pkg::CMD_FILL: begin
                sweep_val <= 1'b1;
                sweep_cnt <= '0;
                state <= S_SWEEP;
              end
              pfre_pkg::CMD_READ: begin
                is_read <= 1'b1;
                state <= S_RDA;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_PA: begin
          // memory read of the pixel byte is under way when on screen
          state <= pix_in ? S_PB : ret;
        end
        S_PB: state <= ret;
        S_RUN: begin
          if (run_pos < run_end) begin
            px <= ppx;
            py <= ppy;
            pon <= pval;
            run_pos <= run_pos + ONE_C;
            ret <= S_RUN;
            state <= S_PA;
          end else begin
            state <= run_ret;
          end
        end
        S_LINE: begin
          px <= ppx;
          py <= ppy;
          pon <= pval;
          ret <= S_LSTEP;
          state <= S_PA;
        end
        S_LSTEP: begin
          if (ax == bx && ay == by) begin
            state <= S_DONE;
          end else begin
            err <= err_next;
            if (mv_x) ax <= ax + dstep_x;
            if (mv_y) ay <= ay + dstep_y;
            state <= S_LINE;
          end
        end
        S_ROUT, S_FROW, S_CFIRST: begin
          if ((state == S_ROUT && k == 4'd4) || (state == S_FROW && !(row < rowend))) begin
            state <= S_DONE;
          end else begin
            run_pos <= cmax0(rs);
            run_end <= cmin(rs + rl, rv ? SH_C : SW_C);
            run_fix <= rf;
            run_vert <= rv;
            k <= k + 1'b1;
            row <= row + ONE_C;
            run_ret <= (state == S_CFIRST) ? S_CTOP : state;
            state <= S_RUN;
          end
        end
        S_CTOP: begin
          k <= '0;
          state <= (cxr >= cyv) ? S_CPT : S_DONE;
        end
        S_CPT: begin
          if (fill_c) begin
            if (k == 4'd4) begin
              state <= S_CUPD;
            end else begin
              run_pos <= cmax0(rs);
              run_end <= cmin(rs + rl, SH_C);
              run_fix <= rf;
              run_vert <= 1'b1;
              k <= k + 1'b1;
              run_ret <= S_CPT;
              state <= S_RUN;
            end
          end else begin
            if (k == 4'd8) begin
              state <= S_CUPD;
            end else begin
              px <= ppx;
              py <= ppy;
              pon <= pval;
              k <= k + 1'b1;
              ret <= S_CPT;
              state <= S_PA;
            end
          end
        end
        S_CUPD: begin
          cyv <= cu_y;
          cxr <= cu_x;
          cerr <= cu_e;
          state <= S_CTOP;
        end
        S_GPT: begin
          if (gcol == 3'(pfre_pkg::CELL_COLS)) begin
            state <= S_DONE;
          end else begin
            px <= ppx;
            py <= ppy;
            pon <= pval;
            if (grow == 3'(pfre_pkg::GLYPH_ROWS - 1)) begin
              grow <= '0;
              gcol <= gcol + 1'b1;
            end else begin
              grow <= grow + 1'b1;
            end
            ret <= S_GPT;
            state <= S_PA;
          end
        end
        S_RDA: begin
          rd_ok <= (32'(cmd_read_index_q) < 32'(pfre_pkg::STORE_BYTES));
          state <= S_RDB;
        end
        S_RDB: begin
          rd_byte <= rd_ok ? mem_rdata : 8'd0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_data.read_data <= is_read ? rd_byte : 8'd0;
            out_data.read_valid <= is_read;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("frame store written while idle");

  a_pb_on_screen: assert property (@(posedge clk) disable iff (rst)
    (state == S_PB) |-> pix_in)
    else $error("pixel write off screen");

  a_pa_to_pb: assert property (@(posedge clk) disable iff (rst)
    (state == S_PA && pix_in) |=> (state == S_PB))
    else $error("read of visible pixel not followed by write");

  a_res_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.read_valid) |-> (out_data.read_data == 8'd0))
    else $error("nonzero data on a drawing result");

endmodule
